@@ hdl/blmf_pkg.sv @@
// ---------------------------------------------------------------------------
// blmf_pkg
// Shared widths, codes and hash constants for the bloom filter block.
// ---------------------------------------------------------------------------
`default_nettype none
package blmf_pkg;

  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 17;
  localparam int PROBE_W = 5;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic REG_BIT_COUNT   = 1'b0;
  localparam logic REG_PROBE_COUNT = 1'b1;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

  localparam logic [PROBE_W-1:0] PROBES_RST = 5'd7;
  localparam logic [PROBE_W-1:0] PROBES_MAX = 5'd30;
  localparam logic [PROBE_W-1:0] PROBES_MIN = 5'd1;
  localparam int                 MIN_BITS   = 64;

endpackage
`default_nettype wire

@@ hdl/blmf_if.sv @@
// ---------------------------------------------------------------------------
// blmf_key_if / blmf_res_if
// Valid/ready channels for key bytes in and result words out.
// ---------------------------------------------------------------------------
`default_nettype none
interface blmf_key_if;
  logic                       valid;
  logic                       ready;
  logic [blmf_pkg::OP_W-1:0]  op;
  logic [7:0]                 data_byte;
  logic                       byte_valid;
  logic                       last_byte;
  modport source (output valid, op, data_byte, byte_valid, last_byte, input ready);
  modport sink   (input valid, op, data_byte, byte_valid, last_byte, output ready);
endinterface

interface blmf_res_if;
  logic                        valid;
  logic                        ready;
  logic [blmf_pkg::KIND_W-1:0] result_kind;
  logic                        maybe_present;
  modport source (output valid, result_kind, maybe_present, input ready);
  modport sink   (input valid, result_kind, maybe_present, output ready);
endinterface
`default_nettype wire

@@ hdl/blmf_ram.sv @@
// ---------------------------------------------------------------------------
// blmf_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module blmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/blmf_rem.sv @@
// ---------------------------------------------------------------------------
// blmf_rem
// Restoring remainder unit: 32-bit dividend modulo a narrow divisor,
// one dividend bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module blmf_rem #(
  parameter int BW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   dividend,
  input  wire logic [BW-1:0] divisor,
  output logic               done,
  output logic [BW-1:0]      rem
);
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic [BW:0] r2;
  logic [BW:0] dsr;

  assign r2  = {rem, quo[31]};
  assign dsr = {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (r2 >= dsr) begin
          rem <= BW'(r2 - dsr);
        end else begin
          rem <= r2[BW-1:0];
        end
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/bloom_filter_insert_query.sv @@
// ---------------------------------------------------------------------------
// bloom_filter_insert_query
// Byte-serial bloom filter: add, query and clear over an on-chip bit store.
// ---------------------------------------------------------------------------
// key_in carries one key byte per word with its op; the op on the word that
// has last_byte set decides add or query, op 2 clears, op 3 is dropped.
// res_out gives one word per finished key (kind 0 add, 1 query with
// maybe_present) or per clear (kind 2). cfg_we/cfg_index/cfg_wdata write
// bit_count (index 0) and probe_count (index 1); the user is to write them
// only while the block is idle, which the block itself does not enforce.
// A final byte runs the finaliser (two 64x64 products built from four
// 64x16 partial products), then per probe the bit-serial modulo, a store
// read and, for an add, a read-modify-write of one byte; the result
// register is loaded last. The remainder unit sets the probe rate. A clear,
// and reset, sweeps all FILTER_BITS_MAX/8 store bytes (8192 by default) one
// byte a cycle; key_in is held off during the sweep and configuration
// writes are still taken. Results sit in an output register, so a new key
// may start while res_out is stalled; a second result waits until the
// first is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module bloom_filter_insert_query #(
  parameter int FILTER_BITS_MAX = 65536
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  blmf_key_if.sink                           key_in,
  blmf_res_if.source                         res_out,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [blmf_pkg::CFG_W-1:0]    cfg_wdata
);
  localparam int DEPTH    = (FILTER_BITS_MAX + 7) / 8;
  localparam int AW       = $clog2(DEPTH);
  localparam int BW       = $clog2(FILTER_BITS_MAX + 1);
  localparam int BITS_RST = (FILTER_BITS_MAX < 65536) ? FILTER_BITS_MAX : 65536;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MULA = 8'b0000_0010,
    S_MULB = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_RD   = 8'b0001_0000,
    S_CHK  = 8'b0010_0000,
    S_CLR  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t                        state;
  logic [63:0]                   acc;
  logic [63:0]                   v;
  logic [63:0]                   prod;
  logic [1:0]                    mcnt;
  logic [31:0]                   pos;
  logic [31:0]                   stride;
  logic [BW-1:0]                 bitpos;
  logic [BW-1:0]                 bits_eff;
  logic [blmf_pkg::PROBE_W-1:0]  probes;
  logic [blmf_pkg::PROBE_W-1:0]  pidx;
  logic [AW-1:0]                 clr_addr;
  logic                          clr_reply;
  logic                          all_set;
  logic [blmf_pkg::KIND_W-1:0]   kind;
  logic                          out_valid;
  logic [blmf_pkg::KIND_W-1:0]   out_kind;
  logic                          out_present;

  logic                          in_acc;
  logic [63:0]                   fx;
  logic [63:0]                   acc_fold;
  logic [15:0]                   seg;
  logic [79:0]                   pp;
  logic [63:0]                   pp_sh;
  logic [63:0]                   prod_next;
  logic [63:0]                   h;
  logic                          div_start;
  logic [31:0]                   div_dividend;
  logic                          div_done;
  logic [BW-1:0]                 div_rem;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [7:0]                    ram_rdata;
  logic [AW-1:0]                 idx;
  logic [7:0]                    mask;
  logic                          out_load;
  logic [31:0]                   cfg_bits;

  assign key_in.ready = (state == S_IDLE);
  assign in_acc       = key_in.valid && key_in.ready;

  // FNV-1a fold; the prime multiply is a 40-bit shift plus a 9-bit product
  assign fx       = acc ^ {56'd0, key_in.data_byte};
  assign acc_fold = key_in.byte_valid ?
                    ({fx[23:0], 40'd0} + 64'(fx * 64'(blmf_pkg::FNV_PRIME_LO))) : acc;

  always_comb begin
    case (mcnt)
      2'd0:    seg = (state == S_MULA) ? blmf_pkg::MIX_MUL_A[15:0]  : blmf_pkg::MIX_MUL_B[15:0];
      2'd1:    seg = (state == S_MULA) ? blmf_pkg::MIX_MUL_A[31:16] : blmf_pkg::MIX_MUL_B[31:16];
      2'd2:    seg = (state == S_MULA) ? blmf_pkg::MIX_MUL_A[47:32] : blmf_pkg::MIX_MUL_B[47:32];
      2'd3:    seg = (state == S_MULA) ? blmf_pkg::MIX_MUL_A[63:48] : blmf_pkg::MIX_MUL_B[63:48];
      default: seg = '0;
    endcase
  end

  assign pp = 80'(v) * 80'(seg);

  always_comb begin
    case (mcnt)
      2'd0:    pp_sh = pp[63:0];
      2'd1:    pp_sh = {pp[47:0], 16'd0};
      2'd2:    pp_sh = {pp[31:0], 32'd0};
      2'd3:    pp_sh = {pp[15:0], 48'd0};
      default: pp_sh = '0;
    endcase
  end

  assign prod_next = prod + pp_sh;
  assign h         = prod_next ^ (prod_next >> 31);

  assign idx  = AW'(bitpos >> 3);
  assign mask = 8'd1 << bitpos[2:0];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = pos + stride;
    if (state == S_MULB && mcnt == 2'd3) begin
      div_start    = 1'b1;
      div_dividend = h[31:0];
    end else if (state == S_CHK && pidx != probes - 5'd1) begin
      div_start = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata | mask;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_CHK && kind == blmf_pkg::KIND_ADD) begin
      ram_we = 1'b1;
    end
  end

  assign out_load = (state == S_DONE) && (!out_valid || res_out.ready);
  assign cfg_bits = 32'(cfg_wdata);

  blmf_rem #(.BW(BW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (bits_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  blmf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_eff <= BW'(BITS_RST);
      probes   <= blmf_pkg::PROBES_RST;
    end else if (cfg_we) begin
      if (cfg_index == blmf_pkg::REG_BIT_COUNT) begin
        if (cfg_bits > 32'(FILTER_BITS_MAX)) begin
          bits_eff <= BW'(FILTER_BITS_MAX);
        end else if (cfg_bits < 32'(blmf_pkg::MIN_BITS)) begin
          bits_eff <= BW'(blmf_pkg::MIN_BITS);
        end else begin
          bits_eff <= BW'(cfg_bits);
        end
      end else begin
        if (cfg_wdata[4:0] < blmf_pkg::PROBES_MIN) begin
          probes <= blmf_pkg::PROBES_MIN;
        end else if (cfg_wdata[4:0] > blmf_pkg::PROBES_MAX) begin
          probes <= blmf_pkg::PROBES_MAX;
        end else begin
          probes <= cfg_wdata[4:0];
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      acc       <= blmf_pkg::FNV_BASIS;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (key_in.op == blmf_pkg::OP_CLEAR) begin
              acc       <= blmf_pkg::FNV_BASIS;
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              kind      <= blmf_pkg::KIND_CLEAR;
              state     <= S_CLR;
            end else if (key_in.op != blmf_pkg::OP_NONE) begin
              if (key_in.last_byte) begin
                acc     <= blmf_pkg::FNV_BASIS;
                v       <= acc_fold ^ (acc_fold >> 30);
                prod    <= '0;
                mcnt    <= '0;
                all_set <= 1'b1;
                kind    <= (key_in.op == blmf_pkg::OP_ADD) ? blmf_pkg::KIND_ADD
                                                           : blmf_pkg::KIND_QUERY;
                state   <= S_MULA;
              end else begin
                acc <= acc_fold;
              end
            end
          end
        end
        S_MULA: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd3) begin
            v     <= prod_next ^ (prod_next >> 27);
            prod  <= '0;
            state <= S_MULB;
          end else begin
            prod <= prod_next;
          end
        end
        S_MULB: begin
          mcnt <= mcnt + 2'd1;
          prod <= prod_next;
          if (mcnt == 2'd3) begin
            pos    <= h[31:0];
            stride <= h[63:32] | 32'd1;
            pidx   <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            bitpos <= div_rem;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if ((ram_rdata & mask) == 8'd0) begin
            all_set <= 1'b0;
          end
          pos  <= pos + stride;
          pidx <= pidx + 5'd1;
          state <= (pidx == probes - 5'd1) ? S_DONE : S_DIV;
        end
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= clr_reply ? S_DONE : S_IDLE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid   <= 1'b1;
      out_kind    <= kind;
      out_present <= (kind == blmf_pkg::KIND_QUERY) && all_set;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.result_kind   = out_kind;
  assign res_out.maybe_present = out_present;

`ifndef SYNTH
  a_last_starts_hash: assert property (@(posedge clk) disable iff (rst)
    (in_acc && key_in.last_byte && (key_in.op == blmf_pkg::OP_ADD ||
     key_in.op == blmf_pkg::OP_QUERY)) |=> (state == S_MULA))
    else $error("final key byte did not start the finaliser");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_rem < bits_eff))
    else $error("probe position not below bit count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR || state == S_DIV) |-> !key_in.ready)
    else $error("key word accepted while sweeping or probing");

  a_one_start: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_start)
    else $error("remainder unit restarted back to back");
`endif
endmodule
`default_nettype wire

@@ tb/bloom_filter_insert_query_tb.sv @@
// ---------------------------------------------------------------------------
// bloom_filter_insert_query_tb
// Self-checking bench for the byte-serial bloom filter. Key words are driven
// from a queue with random gaps and results are taken with random stalls.
// A local model of the hash and bit store predicts each result.
// ---------------------------------------------------------------------------
`default_nettype none
module bloom_filter_insert_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FNV_MUL   = 64'h100000001b3;
  localparam int          STALL_MAX = 30000;

  typedef struct packed {
    logic [blmf_pkg::OP_W-1:0] op;
    logic [7:0]                data;
    logic                      bv;
    logic                      last;
  } key_word_t;

  typedef struct packed {
    logic [blmf_pkg::KIND_W-1:0] kind;
    logic                        present;
  } answer_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [blmf_pkg::CFG_W-1:0] cfg_wdata;

  blmf_key_if key_in();
  blmf_res_if res_out();

  bloom_filter_insert_query u_dut (
    .clk(clk), .rst(rst), .key_in(key_in.sink), .res_out(res_out.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  key_word_t   pending_words[$];
  answer_t     answers_due[$];
  bit          filter_bits[0:65535];
  logic [63:0] fold_hash;
  int unsigned bits_cfg;
  int unsigned probes_cfg;
  bit          failed;
  bit          burst;
  int          send_gap;
  int          take_stall;
  int          idle_cycles;
  int          clear_count;
  int          phase_words;
  int unsigned added_ids[$];
  int unsigned added_lens[$];

  function automatic logic [63:0] splitmix_final(input logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * blmf_pkg::MIX_MUL_A;
    v = v ^ (v >> 27);
    v = v * blmf_pkg::MIX_MUL_B;
    v = v ^ (v >> 31);
    return v;
  endfunction

  function automatic void wipe_filter();
    foreach (filter_bits[i]) filter_bits[i] = 1'b0;
  endfunction

  // fold one accepted word and queue its answer, if it has one
  function automatic void predict_word(input key_word_t w);
    logic [63:0] h;
    logic [31:0] pos, stride, bit_pos, nbits;
    int unsigned k;
    logic all_set;
    answer_t a;
    if (w.op == blmf_pkg::OP_NONE) return;
    if (w.op == blmf_pkg::OP_CLEAR) begin
      wipe_filter();
      fold_hash = blmf_pkg::FNV_BASIS;
      a.kind = blmf_pkg::KIND_CLEAR;
      a.present = 1'b0;
      answers_due = {answers_due, a};
      return;
    end
    if (w.bv) fold_hash = (fold_hash ^ {56'd0, w.data}) * FNV_MUL;
    if (!w.last) return;
    h = splitmix_final(fold_hash);
    fold_hash = blmf_pkg::FNV_BASIS;
    pos = h[31:0];
    stride = h[63:32] | 32'd1;
    nbits = (bits_cfg < blmf_pkg::MIN_BITS) ? blmf_pkg::MIN_BITS : bits_cfg;
    k = (probes_cfg < blmf_pkg::PROBES_MIN) ? blmf_pkg::PROBES_MIN :
        (probes_cfg > blmf_pkg::PROBES_MAX) ? blmf_pkg::PROBES_MAX : probes_cfg;
    all_set = 1'b1;
    for (int i = 0; i < k; i++) begin
      bit_pos = pos % nbits;
      if (w.op == blmf_pkg::OP_ADD) filter_bits[bit_pos[15:0]] = 1'b1;
      else if (!filter_bits[bit_pos[15:0]]) all_set = 1'b0;
      pos = pos + stride;
    end
    a.kind = (w.op == blmf_pkg::OP_ADD) ? blmf_pkg::KIND_ADD : blmf_pkg::KIND_QUERY;
    a.present = (w.op == blmf_pkg::OP_ADD) ? 1'b0 : all_set;
    answers_due = {answers_due, a};
  endfunction

  task automatic push_word(input logic [blmf_pkg::OP_W-1:0] op, input logic [7:0] d,
                           input logic bv, input logic last);
    key_word_t w;
    w.op = op; w.data = d; w.bv = bv; w.last = last;
    pending_words = {pending_words, w};
    if (op != blmf_pkg::OP_NONE) phase_words++;
  endtask

  // key bytes follow from an id so a key can be replayed for a query
  task automatic push_key(input logic [blmf_pkg::OP_W-1:0] op, input int unsigned id,
                          input int unsigned len);
    logic [blmf_pkg::OP_W-1:0] early_op;
    for (int j = 0; j < len; j++) begin
      early_op = ($urandom_range(0, 1) != 0) ? blmf_pkg::OP_QUERY : blmf_pkg::OP_ADD;
      push_word((j == len - 1) ? op : early_op, 8'(id >> (8 * (j % 4))) ^ 8'(j),
                1'b1, j == len - 1);
    end
    if (len == 0) push_word(op, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic write_reg(input logic idx, input logic [blmf_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == blmf_pkg::REG_BIT_COUNT) bits_cfg = (val > 65536) ? 65536 : val;
    else probes_cfg = val[blmf_pkg::PROBE_W-1:0];
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !key_in.valid && answers_due.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(input int target);
    int unsigned id, len, r, pick;
    phase_words = 0;
    while (phase_words < target) begin
      r = $urandom_range(0, 99);
      if (r < 40 || added_ids.size() == 0) begin
        id = $urandom;
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        push_key(blmf_pkg::OP_ADD, id, len);
        added_ids = {added_ids, id};
        added_lens = {added_lens, len};
      end else if (r < 70) begin
        pick = $urandom_range(0, added_ids.size() - 1);
        push_key(blmf_pkg::OP_QUERY, added_ids[pick], added_lens[pick]);
      end else if (r < 85) begin
        push_key(blmf_pkg::OP_QUERY, $urandom, $urandom_range(0, 6));
      end else if (r < 97) begin
        // broken key: mixed ops, some bytes not part of the key
        len = $urandom_range(1, 5);
        for (int j = 0; j < len; j++)
          push_word(($urandom_range(0, 1) != 0) ? blmf_pkg::OP_QUERY : blmf_pkg::OP_ADD,
                    8'($urandom), 1'($urandom), j == len - 1);
      end else if (r < 99 || clear_count >= 4) begin
        push_word(blmf_pkg::OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        push_word(blmf_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
        added_ids.delete();
        added_lens.delete();
        clear_count++;
      end
    end
  endtask

  // key driver
  always @(posedge clk) begin
    if (rst) begin
      key_in.valid <= 1'b0;
      send_gap <= 0;
    end else if (!key_in.valid || key_in.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        key_in.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        key_word_t w;
        w = pending_words.pop_front();
        key_in.op <= w.op;
        key_in.data_byte <= w.data;
        key_in.byte_valid <= w.bv;
        key_in.last_byte <= w.last;
        key_in.valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) burst <= ~burst;
        send_gap <= burst ? 0 : $urandom_range(0, 7);
      end else begin
        key_in.valid <= 1'b0;
      end
    end
  end

  // monitor, result stalls and watchdog
  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
      take_stall <= 0;
      idle_cycles <= 0;
    end else begin
      if (key_in.valid && key_in.ready)
        predict_word({key_in.op, key_in.data_byte, key_in.byte_valid, key_in.last_byte});
      if (res_out.valid && res_out.ready) begin
        int s;
        s = burst ? 0 : $urandom_range(0, 7);
        if (answers_due.size() == 0) begin
          $display("%0t: result word with none due: kind %0d present %0d", $time,
                   res_out.result_kind, res_out.maybe_present);
          failed = 1'b1;
        end else begin
          answer_t a;
          a = answers_due.pop_front();
          if (a.kind !== res_out.result_kind || a.present !== res_out.maybe_present) begin
            $display("%0t: mismatch: expected kind %0d present %0d, got kind %0d present %0d",
                     $time, a.kind, a.present, res_out.result_kind, res_out.maybe_present);
            failed = 1'b1;
          end
        end
        take_stall <= s;
        res_out.ready <= (s == 0);
      end else if (take_stall != 0) begin
        take_stall <= take_stall - 1;
        res_out.ready <= (take_stall == 1);
      end else begin
        res_out.ready <= 1'b1;
      end
      if ((key_in.valid && key_in.ready) || (res_out.valid && res_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    key_in.valid = 1'b0;
    key_in.op = blmf_pkg::OP_NONE;
    key_in.data_byte = 8'd0;
    key_in.byte_valid = 1'b0;
    key_in.last_byte = 1'b0;
    res_out.ready = 1'b0;
    failed = 1'b0;
    burst = 1'b0;
    clear_count = 0;
    fold_hash = blmf_pkg::FNV_BASIS;
    bits_cfg = 65536;
    probes_cfg = blmf_pkg::PROBES_RST;
    wipe_filter();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty keys, byte extremes, op only on last byte, partial
    // key dropped by a clear, ignored op, present after add
    phase_words = 0;
    push_key(blmf_pkg::OP_QUERY, 0, 0);
    push_key(blmf_pkg::OP_ADD, 0, 0);
    push_key(blmf_pkg::OP_QUERY, 0, 0);
    push_word(blmf_pkg::OP_QUERY, 8'h00, 1'b1, 1'b0);
    push_word(blmf_pkg::OP_QUERY, 8'hff, 1'b1, 1'b0);
    push_word(blmf_pkg::OP_ADD, 8'hff, 1'b1, 1'b1);
    push_word(blmf_pkg::OP_ADD, 8'h00, 1'b1, 1'b0);
    push_word(blmf_pkg::OP_QUERY, 8'hff, 1'b1, 1'b0);
    push_word(blmf_pkg::OP_QUERY, 8'h00, 1'b0, 1'b1);
    push_word(blmf_pkg::OP_NONE, 8'hff, 1'b1, 1'b1);
    push_word(blmf_pkg::OP_ADD, 8'h5a, 1'b1, 1'b0);
    push_word(blmf_pkg::OP_CLEAR, 8'ha5, 1'b1, 1'b1);
    push_word(blmf_pkg::OP_QUERY, 8'hff, 1'b1, 1'b1);
    push_key(blmf_pkg::OP_ADD, 32'hdeadbeef, 4);
    push_key(blmf_pkg::OP_QUERY, 32'hdeadbeef, 4);
    push_key(blmf_pkg::OP_QUERY, 32'h12345678, 3);
    clear_count = 1;
    drain();

    write_reg(blmf_pkg::REG_BIT_COUNT, 17'd64);
    write_reg(blmf_pkg::REG_PROBE_COUNT, 17'd1);
    random_phase(180);
    drain();
    write_reg(blmf_pkg::REG_BIT_COUNT, 17'h1ffff);
    write_reg(blmf_pkg::REG_PROBE_COUNT, 17'd31);
    random_phase(170);
    drain();
    write_reg(blmf_pkg::REG_BIT_COUNT, 17'd0);
    write_reg(blmf_pkg::REG_PROBE_COUNT, 17'd0);
    random_phase(170);
    drain();
    write_reg(blmf_pkg::REG_BIT_COUNT, 17'd65536);
    write_reg(blmf_pkg::REG_PROBE_COUNT, 17'd30);
    random_phase(90);
    drain();
    write_reg(blmf_pkg::REG_BIT_COUNT, 17'(8 * $urandom_range(8, 1024)));
    write_reg(blmf_pkg::REG_PROBE_COUNT, 17'($urandom_range(2, 12)));
    random_phase(220);
    drain();
    write_reg(blmf_pkg::REG_BIT_COUNT, 17'd65536 - 17'($urandom_range(0, 65536)));
    write_reg(blmf_pkg::REG_PROBE_COUNT, 17'(blmf_pkg::PROBES_RST));
    random_phase(200);

    wait (pending_words.size() == 0 && !key_in.valid && answers_due.size() == 0);
    repeat (200) @(posedge clk);
    if (!failed)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
